@@ sv/dnf_pkg.sv @@
// ----------------------------------------------------------------------------
// dnf_pkg
// Shared constants, codes, control struct and sigmoid table builder for the
// dense network forward core.
// ----------------------------------------------------------------------------
package dnf_pkg;

    localparam int DNF_MAX_LAYERS   = 4;
    localparam int DNF_MAX_NEURONS  = 64;
    localparam int DNF_SIG_DEPTH    = 256;

    // item actions
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_INPUT  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_INPUT_COUNT  = 3'd0;
    localparam logic [2:0] REG_LAYER_COUNT  = 3'd1;
    localparam logic [2:0] REG_FIRST_SIZE   = 3'd2;
    localparam logic [2:0] REG_SECOND_SIZE  = 3'd3;
    localparam logic [2:0] REG_THIRD_SIZE   = 3'd4;
    localparam logic [2:0] REG_FOURTH_SIZE  = 3'd5;

    typedef struct packed {
        logic load;   // load accumulator with bias
        logic issue;  // weight/activation read issued this cycle
        logic round;  // round, saturate and look up sigmoid
    } mac_ctrl_t;

    // Shift-subtract quotient for the table builder; elaboration only.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid table entry k: evaluated at elaboration only.
    function automatic logic [12:0] sig_entry(int unsigned K, int unsigned Depth);
        logic [63:0]  odd;
        logic [63:0]  m;
        logic [63:0]  t;
        logic [63:0]  n;
        logic [63:0]  f;
        logic [63:0]  term;
        logic [63:0]  e;
        logic [63:0]  d;
        logic [127:0] p;
        logic signed [67:0] sum;
        logic         nonneg;
        logic [63:0]  r;
        odd    = 64'(2 * K + 1);
        nonneg = (odd >= 64'(Depth));
        m      = nonneg ? odd - 64'(Depth) : 64'(Depth) - odd;
        t      = udiv64((64'd16 * m) << 32, 64'(Depth));
        n      = t >> 32;
        f      = {32'd0, t[31:0]};
        term   = 64'h1_0000_0000;
        sum    = 68'sh1_0000_0000;
        for (int i = 1; i <= 16; i++)
        begin
            p    = 128'(term) * 128'(f);
            term = udiv64(64'(p >> 32), 64'(i));
            if (i[0] == 1'b1)
                sum = sum - $signed({4'd0, term});
            else
                sum = sum + $signed({4'd0, term});
        end
        if (sum < 0)
            sum = 0;
        e = 64'(sum);
        if (e > 64'h1_0000_0000)
            e = 64'h1_0000_0000;
        for (int i = 0; i < 64; i++)
        begin
            if (64'(i) < n)
            begin
                p = 128'(e) * 128'd1580030169;
                e = 64'(p >> 32);
            end
        end
        d = 64'h1_0000_0000 + e;
        if (nonneg)
            r = udiv64((64'd1 << 44) + (d >> 1), d);
        else
            r = udiv64(64'd4096 * e + (d >> 1), d);
        return r[12:0];
    endfunction

endpackage

@@ sv/dnf_param_mem.sv @@
// ----------------------------------------------------------------------------
// dnf_param_mem
// Weight and bias stores: one write and one registered read port each.
// ----------------------------------------------------------------------------
module dnf_param_mem #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 64,
    parameter int WAW = $clog2(MAX_LAYERS * MAX_NEURONS * MAX_NEURONS),
    parameter int BAW = $clog2(MAX_LAYERS * MAX_NEURONS)
) (
    input  logic                clk,
    input  logic                w_wr_en,
    input  logic [WAW-1:0]      w_wr_addr,
    input  logic [WAW-1:0]      w_rd_addr,
    input  logic                b_wr_en,
    input  logic [BAW-1:0]      b_wr_addr,
    input  logic [BAW-1:0]      b_rd_addr,
    input  logic signed [15:0]  wr_data,
    output logic signed [15:0]  w_rd_data,
    output logic signed [15:0]  b_rd_data
);
    localparam int WDEPTH = MAX_LAYERS * MAX_NEURONS * MAX_NEURONS;
    localparam int BDEPTH = MAX_LAYERS * MAX_NEURONS;

    logic signed [15:0] weight_mem [WDEPTH];
    logic signed [15:0] bias_mem   [BDEPTH];

    always_ff @(posedge clk)
    begin
        if (w_wr_en)
            weight_mem[w_wr_addr] <= wr_data;
        w_rd_data <= weight_mem[w_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_wr_en)
            bias_mem[b_wr_addr] <= wr_data;
        b_rd_data <= bias_mem[b_rd_addr];
    end
endmodule

@@ sv/dnf_act_mem.sv @@
// ----------------------------------------------------------------------------
// dnf_act_mem
// Ping/pong activation stores; one side is read while the other is written.
// ----------------------------------------------------------------------------
module dnf_act_mem #(
    parameter int MAX_NEURONS = 64,
    parameter int NW = $clog2(MAX_NEURONS)
) (
    input  logic               clk,
    input  logic [NW-1:0]      rd_addr,
    input  logic               rd_sel,
    input  logic               wr_en,
    input  logic               wr_sel,
    input  logic [NW-1:0]      wr_addr,
    input  logic signed [15:0] wr_data,
    output logic signed [15:0] rd_data
);
    logic signed [15:0] ping_mem [MAX_NEURONS];
    logic signed [15:0] pong_mem [MAX_NEURONS];
    logic signed [15:0] ping_q;
    logic signed [15:0] pong_q;
    logic               sel_q;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_sel)
            ping_mem[wr_addr] <= wr_data;
        ping_q <= ping_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_sel)
            pong_mem[wr_addr] <= wr_data;
        pong_q <= pong_mem[rd_addr];
        sel_q  <= rd_sel;
    end

    assign rd_data = sel_q ? pong_q : ping_q;
endmodule

@@ sv/dnf_neuron.sv @@
// ----------------------------------------------------------------------------
// dnf_neuron
// Multiply-accumulate pipeline, rounding to Q4.12 and sigmoid lookup.
// ----------------------------------------------------------------------------
module dnf_neuron #(
    parameter int MAX_NEURONS = 64,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dnf_pkg::mac_ctrl_t ctrl,
    input  logic signed [15:0] bias,
    input  logic signed [15:0] weight,
    input  logic signed [15:0] act,
    output logic [12:0]        sig_value
);
    import dnf_pkg::*;

    localparam int NW = $clog2(MAX_NEURONS);
    localparam int AW = 33 + NW;
    localparam int TW = $clog2(SIGMOID_TABLE_DEPTH);

    logic [12:0]           sig_rom [SIGMOID_TABLE_DEPTH];
    logic                  data_v_reg;
    logic                  prod_v_reg;
    logic signed [31:0]    prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [12:0]           sig_reg;
    logic signed [AW:0]    acc_rnd;
    logic signed [AW-12:0] z_wide;
    logic signed [15:0]    z_sat;
    logic [15:0]           z_off;
    logic [16+TW:0]        idx_prod;
    logic [TW-1:0]         idx;

    for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [12:0] ENTRY = sig_entry(k, SIGMOID_TABLE_DEPTH);
        assign sig_rom[k] = ENTRY;
    end

    always_comb
    begin
        acc_rnd = (AW+1)'(acc_reg) + (AW+1)'(2048);
        z_wide  = acc_rnd[AW:12];
        if (z_wide > (AW-11)'(32767))
            z_sat = 16'sh7fff;
        else if (z_wide < -(AW-11)'(32768))
            z_sat = -16'sh8000;
        else
            z_sat = z_wide[15:0];
        z_off    = z_sat ^ 16'h8000;
        idx_prod = (17+TW)'(z_off) * (17+TW)'(SIGMOID_TABLE_DEPTH);
        idx      = idx_prod[16+TW-1:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            data_v_reg <= ctrl.issue;
            prod_v_reg <= data_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * act;
        if (ctrl.load)
            acc_reg <= {{(AW-28){bias[15]}}, bias, 12'd0};
        else if (prod_v_reg)
            acc_reg <= acc_reg + AW'(prod_reg);
        if (ctrl.round)
            sig_reg <= sig_rom[idx];
    end

    assign sig_value = sig_reg;
endmodule

@@ sv/dense_network_forward_core.sv @@
// ----------------------------------------------------------------------------
// dense_network_forward_core
// Fully connected network forward pass with sigmoid activations.
//
// Channel   Direction  Handshake              Payload
// input     in         start & !busy          action, layer, neuron, source, value
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
// result    out        strobe (one cycle)     activation, slope, position, last
//
// Weight, bias and input items are accepted while idle. The item that completes
// the input vector starts a run: per neuron the bias, MAC, drain, round and write
// states, on the shared multiply-accumulate unit and each store's single read port.
// Busy stays high for the whole run; the receiver cannot stall results.
// Reset sets all registers to 1 and clears the input counter; stores are
// not cleared.
// ----------------------------------------------------------------------------
module dense_network_forward_core #(
    parameter int MAX_LAYERS          = dnf_pkg::DNF_MAX_LAYERS,
    parameter int MAX_NEURONS         = dnf_pkg::DNF_MAX_NEURONS,
    parameter int SIGMOID_TABLE_DEPTH = dnf_pkg::DNF_SIG_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [1:0]         layer,
    input  logic [5:0]         neuron,
    input  logic [5:0]         source,
    input  logic signed [15:0] value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    output logic               strobe,
    output logic [12:0]        activation,
    output logic [11:0]        slope,
    output logic [5:0]         position,
    output logic               last
);
    import dnf_pkg::*;

    localparam int NW  = $clog2(MAX_NEURONS);
    localparam int CW  = $clog2(MAX_NEURONS + 1);
    localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LCW = $clog2(MAX_LAYERS + 1);
    localparam int WAW = $clog2(MAX_LAYERS * MAX_NEURONS * MAX_NEURONS);
    localparam int BAW = $clog2(MAX_LAYERS * MAX_NEURONS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIAS  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] l_reg, l_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] c_reg, c_next;
    logic [CW-1:0] src_n_reg, src_n_next;
    logic          src_sel_reg, src_sel_next;
    logic          drain_reg, drain_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [6:0]    in_count_reg;
    logic [2:0]    layer_count_reg;
    logic [6:0]    size_reg [4];

    logic          strobe_reg, strobe_next;
    logic [12:0]   activation_reg, activation_next;
    logic [11:0]   slope_reg, slope_next;
    logic [5:0]    position_reg, position_next;
    logic          last_reg, last_next;

    logic          accept;
    logic [CW-1:0] in_count_c;
    logic [LCW-1:0] layers_c;
    logic [6:0]    size_raw;
    logic [CW-1:0] dst_n;
    logic          final_layer;
    logic          last_neuron;
    logic [25:0]   slope_full;

    logic               w_wr_en, b_wr_en;
    logic [WAW-1:0]     w_wr_addr, w_rd_addr;
    logic [BAW-1:0]     b_wr_addr, b_rd_addr;
    logic signed [15:0] w_rd_data, b_rd_data, a_rd_data;
    logic               a_wr_en, a_wr_sel;
    logic [NW-1:0]      a_wr_addr;
    logic signed [15:0] a_wr_data;
    mac_ctrl_t          ctrl;
    logic [12:0]        sig_value;

    function automatic logic [CW-1:0] clamp_size(logic [6:0] v);
        if (v == 7'd0)
            return CW'(1);
        else if (32'(v) > MAX_NEURONS)
            return CW'(MAX_NEURONS);
        else
            return CW'(v);
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_count_c = clamp_size(in_count_reg);
        if (layer_count_reg == 3'd0)
            layers_c = LCW'(1);
        else if (32'(layer_count_reg) > MAX_LAYERS)
            layers_c = LCW'(MAX_LAYERS);
        else
            layers_c = LCW'(layer_count_reg);
        if (32'(l_reg) < 4)
            size_raw = size_reg[2'(l_reg)];
        else
            size_raw = size_reg[3];
        dst_n       = clamp_size(size_raw);
        final_layer = ((LCW'(l_reg) + LCW'(1)) == layers_c);
        last_neuron = ((CW'(j_reg) + CW'(1)) == dst_n);
        slope_full  = 26'({sig_value, 1'b0}) * 26'(13'd4096 - sig_value) + 26'd2048;
    end

    // store write and read addressing
    always_comb
    begin
        w_wr_en   = accept && (action == ACT_WEIGHT) && (32'(layer) < MAX_LAYERS)
                    && (32'(neuron) < MAX_NEURONS) && (32'(source) < MAX_NEURONS);
        b_wr_en   = accept && (action == ACT_BIAS) && (32'(layer) < MAX_LAYERS)
                    && (32'(neuron) < MAX_NEURONS);
        w_wr_addr = WAW'(32'(layer) * MAX_NEURONS * MAX_NEURONS
                    + 32'(neuron) * MAX_NEURONS + 32'(source));
        b_wr_addr = BAW'(32'(layer) * MAX_NEURONS + 32'(neuron));
        w_rd_addr = WAW'(32'(l_reg) * MAX_NEURONS * MAX_NEURONS
                    + 32'(j_reg) * MAX_NEURONS + 32'(c_reg));
        b_rd_addr = BAW'(32'(l_reg) * MAX_NEURONS + 32'(j_reg));
        if (state_reg == S_WRITE)
        begin
            a_wr_en   = 1'b1;
            a_wr_sel  = !src_sel_reg;
            a_wr_addr = j_reg;
            a_wr_data = {3'd0, sig_value};
        end
        else
        begin
            a_wr_en   = accept && (action == ACT_INPUT) && (32'(cnt_reg) < MAX_NEURONS);
            a_wr_sel  = 1'b0;
            a_wr_addr = NW'(cnt_reg);
            a_wr_data = value;
        end
        ctrl.load  = (state_reg == S_MAC) && (c_reg == '0);
        ctrl.issue = (state_reg == S_MAC);
        ctrl.round = (state_reg == S_ROUND);
    end

    always_comb
    begin
        state_next      = state_reg;
        l_next          = l_reg;
        j_next          = j_reg;
        c_next          = c_reg;
        src_n_next      = src_n_reg;
        src_sel_next    = src_sel_reg;
        drain_next      = drain_reg;
        cnt_next        = cnt_reg;
        strobe_next     = 1'b0;
        activation_next = activation_reg;
        slope_next      = slope_reg;
        position_next   = position_reg;
        last_next       = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_INPUT))
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (CW'(cnt_next) >= in_count_c || 32'(cnt_next) > MAX_NEURONS)
                    begin
                        // vector complete: start the run
                        cnt_next     = 7'd0;
                        state_next   = S_BIAS;
                        l_next       = '0;
                        j_next       = '0;
                        src_n_next   = in_count_c;
                        src_sel_next = 1'b0;
                    end
                end
            end
            S_BIAS:
            begin
                c_next     = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if ((CW'(c_reg) + CW'(1)) == src_n_reg)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
                else
                    c_next = c_reg + NW'(1);
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (final_layer)
                begin
                    strobe_next     = 1'b1;
                    activation_next = sig_value;
                    slope_next      = slope_full[23:12];
                    position_next   = 6'(j_reg);
                    last_next       = last_neuron;
                end
                if (last_neuron)
                begin
                    if (final_layer)
                        state_next = S_IDLE;
                    else
                    begin
                        // swap ping and pong, advance layer
                        l_next       = l_reg + LW'(1);
                        j_next       = '0;
                        src_n_next   = dst_n;
                        src_sel_next = !src_sel_reg;
                        state_next   = S_BIAS;
                    end
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_BIAS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            l_reg           <= '0;
            j_reg           <= '0;
            c_reg           <= '0;
            src_n_reg       <= CW'(1);
            src_sel_reg     <= 1'b0;
            drain_reg       <= 1'b0;
            cnt_reg         <= 7'd0;
            strobe_reg      <= 1'b0;
            in_count_reg    <= 7'd1;
            layer_count_reg <= 3'd1;
            size_reg[0]     <= 7'd1;
            size_reg[1]     <= 7'd1;
            size_reg[2]     <= 7'd1;
            size_reg[3]     <= 7'd1;
        end
        else
        begin
            state_reg   <= state_next;
            l_reg       <= l_next;
            j_reg       <= j_next;
            c_reg       <= c_next;
            src_n_reg   <= src_n_next;
            src_sel_reg <= src_sel_next;
            drain_reg   <= drain_next;
            cnt_reg     <= cnt_next;
            strobe_reg  <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_INPUT_COUNT: in_count_reg    <= cfg_data;
                    REG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                    REG_FIRST_SIZE:  size_reg[0]     <= cfg_data;
                    REG_SECOND_SIZE: size_reg[1]     <= cfg_data;
                    REG_THIRD_SIZE:  size_reg[2]     <= cfg_data;
                    REG_FOURTH_SIZE: size_reg[3]     <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        activation_reg <= activation_next;
        slope_reg      <= slope_next;
        position_reg   <= position_next;
        last_reg       <= last_next;
    end

    dnf_param_mem #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_NEURONS (MAX_NEURONS),
        .WAW         (WAW),
        .BAW         (BAW)
    ) u_param_mem (
        .clk       (clk),
        .w_wr_en   (w_wr_en),
        .w_wr_addr (w_wr_addr),
        .w_rd_addr (w_rd_addr),
        .b_wr_en   (b_wr_en),
        .b_wr_addr (b_wr_addr),
        .b_rd_addr (b_rd_addr),
        .wr_data   (value),
        .w_rd_data (w_rd_data),
        .b_rd_data (b_rd_data)
    );

    dnf_act_mem #(
        .MAX_NEURONS (MAX_NEURONS),
        .NW          (NW)
    ) u_act_mem (
        .clk     (clk),
        .rd_addr (c_reg),
        .rd_sel  (src_sel_reg),
        .wr_en   (a_wr_en),
        .wr_sel  (a_wr_sel),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .rd_data (a_rd_data)
    );

    dnf_neuron #(
        .MAX_NEURONS         (MAX_NEURONS),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_neuron (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .bias      (b_rd_data),
        .weight    (w_rd_data),
        .act       (a_rd_data),
        .sig_value (sig_value)
    );

    assign strobe     = strobe_reg;
    assign activation = activation_reg;
    assign slope      = slope_reg;
    assign position   = position_reg;
    assign last       = last_reg;

    a_strobe_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg) == S_WRITE)
        else $error("result strobe without a preceding write-back");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> state_reg == S_IDLE)
        else $error("run still active after last result");

    a_round_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> $past(state_reg) == S_DRAIN && $past(drain_reg))
        else $error("rounding before accumulator drained");
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dense network forward core: loads weights and
// biases, streams input vectors across several layer setups and compares
// every output neuron against a predictor of the fixed-point network.
// ----------------------------------------------------------------------------
module tb_top;
    import dnf_pkg::*;

    typedef struct {
        logic [12:0] act;
        logic [11:0] slp;
        logic [5:0]  pos;
        logic        fin;
    } neuron_out_t;

    typedef struct {
        logic [1:0]         act_code;
        logic [1:0]         lyr;
        logic [5:0]         nrn;
        logic [5:0]         src;
        logic signed [15:0] val;
        bit                 typed;
        logic [12:0]        exp_act;
        logic [11:0]        exp_slp;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [1:0]         layer;
    logic [5:0]         neuron;
    logic [5:0]         source;
    logic signed [15:0] value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [6:0]         cfg_data;
    logic               strobe;
    logic [12:0]        activation;
    logic [11:0]        slope;
    logic [5:0]         position;
    logic               last;

    // predictor state
    logic [12:0]        sig_lut [DNF_SIG_DEPTH];
    logic signed [15:0] wgt [4][64][64];
    logic signed [15:0] bia [4][64];
    bit                 wgt_set [4][64][64];
    bit                 bia_set [4][64];
    int                 ping [64];
    int                 pong [64];
    int                 in_cnt;
    logic [6:0]         regs [6];
    neuron_out_t        pending_outs [$];
    neuron_out_t        step_outs [$];
    int                 err_count;
    bit                 allow_gaps;

    dense_network_forward_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .layer      (layer),
        .neuron     (neuron),
        .source     (source),
        .value      (value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .activation (activation),
        .slope      (slope),
        .position   (position),
        .last       (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic logic [12:0] sigmoid_point(int k);
        bit [63:0] odd;
        bit [63:0] m;
        bit [63:0] t;
        bit [63:0] f;
        bit [63:0] term;
        bit [63:0] e;
        bit [63:0] d;
        longint    acc;
        bit        nonneg;
        odd    = 64'(2 * k + 1);
        nonneg = odd >= 64'(DNF_SIG_DEPTH);
        m      = nonneg ? odd - 64'(DNF_SIG_DEPTH) : 64'(DNF_SIG_DEPTH) - odd;
        t      = ((64'd16 * m) << 32) / 64'(DNF_SIG_DEPTH);
        f      = {32'd0, t[31:0]};
        term   = 64'h1_0000_0000;
        acc    = 64'sh1_0000_0000;
        for (int i = 1; i <= 16; i++)
        begin
            term = ((term * f) >> 32) / 64'(i);
            acc  = (i % 2) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        e = 64'(acc);
        if (e > 64'h1_0000_0000)
            e = 64'h1_0000_0000;
        for (int i = 0; i < int'(t >> 32); i++)
            e = (e * 64'd1580030169) >> 32;
        d = 64'h1_0000_0000 + e;
        if (nonneg)
            return 13'(((64'd1 << 44) + d / 2) / d);
        return 13'((64'd4096 * e + d / 2) / d);
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int layers_used();
        return clampi(regs[REG_LAYER_COUNT], 1, DNF_MAX_LAYERS);
    endfunction

    function automatic int neurons_in(int l);
        return clampi(regs[REG_FIRST_SIZE + (l < 4 ? l : 3)], 1, DNF_MAX_NEURONS);
    endfunction

    function automatic int sources_of(int l);
        return l == 0 ? clampi(regs[REG_INPUT_COUNT], 1, DNF_MAX_NEURONS) : neurons_in(l - 1);
    endfunction

    // forward pass over the current stores; even layers read ping and write
    // pong, odd layers the other way round; fills step_outs
    function automatic void forward_pass();
        int          n_src;
        int          n_dst;
        int          a_in;
        int          a_out;
        longint      acc;
        longint      z;
        bit          odd_layer;
        neuron_out_t o;
        n_src     = sources_of(0);
        n_dst     = 1;
        odd_layer = 1'b0;
        for (int l = 0; l < layers_used(); l++)
        begin
            odd_layer = (l % 2) != 0;
            n_dst = neurons_in(l);
            for (int j = 0; j < n_dst; j++)
            begin
                acc = longint'(bia[l][j]) * 4096;
                for (int c = 0; c < n_src; c++)
                begin
                    a_in = odd_layer ? pong[c] : ping[c];
                    acc += longint'(wgt[l][j][c]) * longint'(a_in);
                end
                z = (acc + 2048) >>> 12;
                z = z > 32767 ? 32767 : (z < -32768 ? -32768 : z);
                a_out = int'(sig_lut[int'((z + 32768) >> 8)]);
                if (odd_layer)
                    ping[j] = a_out;
                else
                    pong[j] = a_out;
            end
            n_src = n_dst;
        end
        for (int j = 0; j < n_dst; j++)
        begin
            a_out = odd_layer ? ping[j] : pong[j];
            o.act = 13'(a_out);
            o.slp = 12'((2 * a_out * (4096 - a_out) + 2048) >> 12);
            o.pos = 6'(j);
            o.fin = (j + 1 == n_dst);
            step_outs.push_back(o);
        end
    endfunction

    function automatic void net_step(logic [1:0] a, logic [1:0] l, logic [5:0] n,
                                     logic [5:0] s, logic signed [15:0] v);
        step_outs.delete();
        case (a)
            ACT_WEIGHT:
            begin
                wgt[l][n][s] = v;
                wgt_set[l][n][s] = 1;
            end
            ACT_BIAS:
            begin
                bia[l][n] = v;
                bia_set[l][n] = 1;
            end
            ACT_INPUT:
            begin
                if (in_cnt < DNF_MAX_NEURONS)
                    ping[in_cnt] = v;
                in_cnt = (in_cnt + 1) & 8'h7f;
                if (in_cnt >= clampi(regs[REG_INPUT_COUNT], 1, DNF_MAX_NEURONS))
                begin
                    in_cnt = 0;
                    forward_pass();
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] a, logic [1:0] l, logic [5:0] n,
                             logic [5:0] s, logic signed [15:0] v);
        int gap;
        start  <= 1'b1;
        action <= a;
        layer  <= l;
        neuron <= n;
        source <= s;
        value  <= v;
        do
            @(posedge clk);
        while (busy);
        net_step(a, l, n, s, v);
        foreach (step_outs[i])
            pending_outs.push_back(step_outs[i]);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold until every output is in and the core has settled
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outs.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        regs[idx] = data;
    endtask

    // load every weight and bias the current setup will read
    task automatic load_missing();
        for (int l = 0; l < layers_used(); l++)
            for (int j = 0; j < neurons_in(l); j++)
            begin
                if (!bia_set[l][j])
                    send_item(ACT_BIAS, 2'(l), 6'(j), 6'($urandom),
                              16'($urandom_range(0, 16383) - 8192));
                for (int c = 0; c < sources_of(l); c++)
                    if (!wgt_set[l][j][c])
                        send_item(ACT_WEIGHT, 2'(l), 6'(j), 6'(c),
                                  16'($urandom_range(0, 16383) - 8192));
            end
    endtask

    task automatic random_items(int count);
        int                 pick;
        int                 l;
        logic signed [15:0] v;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
            l = $urandom_range(0, layers_used() - 1);
            if (pick < 60)
                send_item(ACT_INPUT, 2'($urandom), 6'($urandom), 6'($urandom), v);
            else if (pick < 75)
                send_item(ACT_WEIGHT, 2'(l), 6'($urandom_range(0, neurons_in(l) - 1)),
                          6'($urandom_range(0, sources_of(l) - 1)), v);
            else if (pick < 85)
                send_item(ACT_BIAS, 2'(l), 6'($urandom_range(0, neurons_in(l) - 1)),
                          6'($urandom), v);
            else if (pick < 93)
                send_item(2'($urandom_range(0, 1)), 2'($urandom), 6'($urandom),
                          6'($urandom), v);
            else
                send_item(2'd3, 2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_setup(logic [6:0] ic, logic [6:0] lc, logic [6:0] s1,
                             logic [6:0] s2, logic [6:0] s3, logic [6:0] s4, int count);
        drain_block();
        write_reg(REG_INPUT_COUNT, ic);
        write_reg(REG_LAYER_COUNT, lc);
        write_reg(REG_FIRST_SIZE, s1);
        write_reg(REG_SECOND_SIZE, s2);
        write_reg(REG_THIRD_SIZE, s3);
        write_reg(REG_FOURTH_SIZE, s4);
        cfg_valid <= 1'b0;
        @(posedge clk);
        load_missing();
        random_items(count);
    endtask

    always @(posedge clk)
    begin
        neuron_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_outs.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected output: act %0d slope %0d pos %0d last %0d",
                             activation, slope, position, last);
            end
            else
            begin
                want = pending_outs.pop_front();
                if (activation !== want.act || slope !== want.slp ||
                    position !== want.pos || last !== want.fin)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.act, want.slp, want.pos, want.fin,
                                 activation, slope, position, last);
                end
            end
        end
    end

    stim_row_t   directed [14] = '{
        '{ACT_WEIGHT, 2'd0, 6'd0, 6'd0, 16'sh7fff, 0, 13'd0, 12'd0},
        '{ACT_BIAS,   2'd0, 6'd0, 6'd0, 16'sh7fff, 0, 13'd0, 12'd0},
        '{ACT_INPUT,  2'd0, 6'd0, 6'd0, 16'sh7fff, 1, 13'd4096, 12'd0},
        '{ACT_WEIGHT, 2'd0, 6'd0, 6'd0, -16'sh8000, 0, 13'd0, 12'd0},
        '{ACT_INPUT,  2'd3, 6'd63, 6'd63, 16'sh7fff, 1, 13'd0, 12'd0},
        '{2'd3,       2'd3, 6'd63, 6'd63, 16'shffff, 0, 13'd0, 12'd0},
        '{ACT_BIAS,   2'd0, 6'd0, 6'd63, 16'sh0000, 0, 13'd0, 12'd0},
        '{ACT_WEIGHT, 2'd0, 6'd0, 6'd0, 16'sh0000, 0, 13'd0, 12'd0},
        '{ACT_INPUT,  2'd0, 6'd0, 6'd0, -16'sh8000, 0, 13'd0, 12'd0},
        '{ACT_WEIGHT, 2'd3, 6'd63, 6'd63, -16'sh0001, 0, 13'd0, 12'd0},
        '{ACT_BIAS,   2'd3, 6'd63, 6'd0, 16'sh1000, 0, 13'd0, 12'd0},
        '{ACT_WEIGHT, 2'd0, 6'd0, 6'd0, 16'sh1000, 0, 13'd0, 12'd0},
        '{ACT_INPUT,  2'd1, 6'd21, 6'd42, 16'sh1000, 0, 13'd0, 12'd0},
        '{ACT_INPUT,  2'd2, 6'd42, 6'd21, -16'sh1000, 0, 13'd0, 12'd0}
    };

    initial
    begin
        neuron_out_t o;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_WEIGHT;
        layer      = 2'd0;
        neuron     = 6'd0;
        source     = 6'd0;
        value      = 16'sd0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_INPUT_COUNT;
        cfg_data   = 7'd1;
        err_count  = 0;
        allow_gaps = 1'b1;
        in_cnt     = 0;
        for (int k = 0; k < DNF_SIG_DEPTH; k++)
            sig_lut[k] = sigmoid_point(k);
        foreach (regs[i])
            regs[i] = 7'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset setup: one input, one neuron
        foreach (directed[r])
        begin
            send_item(directed[r].act_code, directed[r].lyr, directed[r].nrn,
                      directed[r].src, directed[r].val);
            if (directed[r].typed)
            begin
                void'(pending_outs.pop_back());
                o.act = directed[r].exp_act;
                o.slp = directed[r].exp_slp;
                o.pos = 6'd0;
                o.fin = 1'b1;
                pending_outs.push_back(o);
            end
        end

        run_setup(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 15);
        run_setup(7'd3, 7'd2, 7'd4, 7'd2, 7'd1, 7'd1, 20);
        run_setup(7'd1, 7'd1, 7'd127, 7'd1, 7'd1, 7'd1, 15);
        run_setup(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 15);
        run_setup(7'd2, 7'd7, 7'd3, 7'd2, 7'd2, 7'd2, 20);
        run_setup(7'd0, 7'd3, 7'd2, 7'd3, 7'd4, 7'd64, 15);
        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                allow_gaps = 1'b0;
            run_setup(7'($urandom_range(1, 6)), 7'($urandom_range(1, 4)),
                      7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)),
                      7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)), 15);
        end

        start <= 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
sv/dnf_pkg.sv
sv/dnf_param_mem.sv
sv/dnf_act_mem.sv
sv/dnf_neuron.sv
sv/dense_network_forward_core.sv
tb/tb_top.sv
